// File: rtl/bcs_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_pkg
// Shared types, codes and constants for the charger supervisor.
// ----------------------------------------------------------------------------
package bcs_pkg;

    // Command codes of an input item
    localparam logic [1:0] CMD_POLL  = 2'd0;
    localparam logic [1:0] CMD_CABLE = 2'd1;
    localparam logic [1:0] CMD_FULL  = 2'd2;

    // Cable kinds
    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_USB  = 2'd1;

    // Configuration register indexes
    localparam logic [2:0] REG_HOT_LIMIT           = 3'd0;
    localparam logic [2:0] REG_HOT_RECOVER         = 3'd1;
    localparam logic [2:0] REG_COLD_RECOVER        = 3'd2;
    localparam logic [2:0] REG_COLD_LIMIT          = 3'd3;
    localparam logic [2:0] REG_RESUME_UV           = 3'd4;
    localparam logic [2:0] REG_CHARGE_TIME_LIMIT   = 3'd5;
    localparam logic [2:0] REG_RECHARGE_TIME_LIMIT = 3'd6;
    localparam logic [2:0] REG_CHARGE_ONLY_BOOT    = 3'd7;

    localparam int CFG_DATA_W = 23;
    localparam int CFG_IDX_W  = 3;
    localparam int TEMP_W     = 12;
    localparam int UV_W       = 23;
    localparam int LIMIT_W    = 20;
    localparam int TIME_W     = 32;

    // Cell voltage above which a timeout is reported as full
    localparam logic [UV_W-1:0] FULL_ON_TIMEOUT_UV = 23'd4150000;

    // Queue between classifier and executor
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_CHARGEABLE = 2'd0,
        ST_FULL       = 2'd1,
        ST_TIMEOUT    = 2'd2,
        ST_ABNORMAL   = 2'd3
    } sup_state_t;

    typedef enum logic [1:0] {
        RPT_DISCHARGING  = 2'd0,
        RPT_CHARGING     = 2'd1,
        RPT_NOT_CHARGING = 2'd2,
        RPT_FULL         = 2'd3
    } report_t;

    typedef enum logic [1:0] {
        HL_GOOD     = 2'd0,
        HL_OVERHEAT = 2'd1,
        HL_COLD     = 2'd2
    } health_t;

    typedef struct packed {
        logic signed [TEMP_W-1:0] hot_limit;
        logic signed [TEMP_W-1:0] hot_recover;
        logic signed [TEMP_W-1:0] cold_recover;
        logic signed [TEMP_W-1:0] cold_limit;
        logic [UV_W-1:0]          resume_uv;
        logic [LIMIT_W-1:0]       charge_time_limit;
        logic [LIMIT_W-1:0]       recharge_time_limit;
        logic                     charge_only_boot;
    } cfg_t;

    // Classified item as it travels through the queue
    typedef struct packed {
        logic              attach;
        logic              detach;
        logic              full_irq;
        logic              hot;
        logic              in_band;
        logic              cold;
        logic              uv_high;
        logic              uv_low;
        logic [1:0]        kind;
        logic [TIME_W-1:0] now;
    } item_t;

endpackage

// File: rtl/bcs_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_front
// Input side: accept transactions and classify them for the executor.
// ----------------------------------------------------------------------------
module bcs_front (
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [1:0]                  cmd,
    input  logic [31:0]                 now_sec,
    input  logic signed [11:0]          temperature,
    input  logic [22:0]                 cell_microvolts,
    input  logic                        cable_present,
    input  logic [1:0]                  cable_kind,
    input  bcs_pkg::cfg_t               cfg,
    input  logic                        q_full,
    output logic                        push,
    output bcs_pkg::item_t              push_item
);
    import bcs_pkg::*;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    always_comb
    begin
        push_item.attach   = (cmd == CMD_CABLE) && cable_present;
        push_item.detach   = (cmd == CMD_CABLE) && !cable_present;
        push_item.full_irq = (cmd == CMD_FULL);
        push_item.hot      = temperature >= cfg.hot_limit;
        push_item.in_band  = (temperature <= cfg.hot_recover)
                          && (temperature >= cfg.cold_recover);
        push_item.cold     = temperature <= cfg.cold_limit;
        push_item.uv_high  = cell_microvolts > FULL_ON_TIMEOUT_UV;
        push_item.uv_low   = cell_microvolts < cfg.resume_uv;
        push_item.kind     = cable_kind;
        push_item.now      = now_sec;
    end

endmodule

// File: rtl/bcs_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_queue
// Short FIFO of classified items between front and back.
// ----------------------------------------------------------------------------
module bcs_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  bcs_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           head_valid,
    output bcs_pkg::item_t head_item
);
    import bcs_pkg::*;

    item_t             entry_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("queue written while full");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("queue read while empty");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue occupancy beyond depth");

endmodule

// File: rtl/bcs_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcs_back
// Executor: supervisor state machine, deadline and output register.
// ----------------------------------------------------------------------------
module bcs_back (
    input  logic           clk,
    input  logic           rst_n,
    input  bcs_pkg::cfg_t  cfg,
    input  logic           head_valid,
    input  bcs_pkg::item_t head_item,
    output logic           pop,
    output logic           out_valid,
    input  logic           out_stall,
    output logic [1:0]     status_code,
    output logic [1:0]     health,
    output logic           charger_enable,
    output logic [1:0]     charge_state
);
    import bcs_pkg::*;

    sup_state_t        state_reg, state_next;
    report_t           status_reg, status_next;
    health_t           health_reg, health_next;
    logic [TIME_W-1:0] deadline_reg, deadline_next;
    logic              attached_reg, attached_next;
    logic [1:0]        kind_reg, kind_next;
    logic              full_seen_reg, full_seen_next;
    logic              once_full_reg, once_full_next;
    logic              enable_reg, enable_next;
    logic              out_valid_reg, out_valid_next;

    logic              gate;
    logic [TIME_W-1:0] arm_sum;

    assign pop = head_valid && (!out_valid_reg || !out_stall);

    assign out_valid      = out_valid_reg;
    assign status_code    = status_reg;
    assign health         = health_reg;
    assign charger_enable = enable_reg;
    assign charge_state   = state_reg;

    always_comb
    begin
        state_next     = state_reg;
        status_next    = status_reg;
        health_next    = health_reg;
        deadline_next  = deadline_reg;
        attached_next  = attached_reg;
        kind_next      = kind_reg;
        full_seen_next = full_seen_reg;
        once_full_next = once_full_reg;
        enable_next    = enable_reg;
        gate           = 1'b0;
        arm_sum        = '0;

        if (pop)
        begin
            // cable and interrupt events first
            if (head_item.attach)
            begin
                attached_next = 1'b1;
                kind_next     = head_item.kind;
                if (cfg.charge_only_boot || head_item.kind != KIND_USB)
                begin
                    status_next = RPT_CHARGING;
                end
            end
            else if (head_item.detach)
            begin
                full_seen_next = 1'b0;
                attached_next  = 1'b0;
                status_next    = RPT_DISCHARGING;
                kind_next      = KIND_NONE;
                once_full_next = 1'b0;
                deadline_next  = '0;
            end
            else if (head_item.full_irq)
            begin
                full_seen_next = 1'b1;
            end
            if (head_item.attach || head_item.detach)
            begin
                state_next  = ST_CHARGEABLE;
                enable_next = (kind_next != KIND_NONE);
            end

            // health with hysteresis
            if (head_item.hot)
            begin
                health_next = HL_OVERHEAT;
            end
            else if (head_item.in_band)
            begin
                health_next = HL_GOOD;
            end
            else if (head_item.cold)
            begin
                health_next = HL_COLD;
            end

            if (attached_next)
            begin
                gate = cfg.charge_only_boot || (kind_next != KIND_USB);
                case (state_next)
                    ST_CHARGEABLE:
                    begin
                        if (deadline_next != '0 && head_item.now > deadline_next)
                        begin
                            if (gate && head_item.uv_high)
                            begin
                                status_next = RPT_FULL;
                            end
                            once_full_next = 1'b1;
                            state_next     = ST_TIMEOUT;
                        end
                        else if (health_next == HL_OVERHEAT || health_next == HL_COLD)
                        begin
                            if (gate)
                            begin
                                status_next = RPT_NOT_CHARGING;
                            end
                            state_next = ST_ABNORMAL;
                        end
                        else if (full_seen_next)
                        begin
                            if (gate)
                            begin
                                status_next    = RPT_FULL;
                                once_full_next = 1'b1;
                            end
                            state_next = ST_FULL;
                        end
                    end
                    ST_ABNORMAL:
                    begin
                        if (head_item.in_band)
                        begin
                            state_next = ST_CHARGEABLE;
                            if (gate)
                            begin
                                status_next = RPT_CHARGING;
                            end
                        end
                    end
                    default:
                    begin
                        if (head_item.uv_low)
                        begin
                            state_next = ST_CHARGEABLE;
                        end
                    end
                endcase

                arm_sum = head_item.now + TIME_W'(once_full_next ? cfg.recharge_time_limit
                                                                  : cfg.charge_time_limit);
                if (state_next == ST_CHARGEABLE)
                begin
                    enable_next = 1'b1;
                    if (deadline_next == '0 && gate)
                    begin
                        deadline_next = arm_sum;
                    end
                end
                else
                begin
                    enable_next   = 1'b0;
                    deadline_next = '0;
                end
            end
        end

        if (pop)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CHARGEABLE;
            status_reg    <= RPT_DISCHARGING;
            health_reg    <= HL_GOOD;
            deadline_reg  <= '0;
            attached_reg  <= 1'b0;
            kind_reg      <= KIND_NONE;
            full_seen_reg <= 1'b0;
            once_full_reg <= 1'b0;
            enable_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            status_reg    <= status_next;
            health_reg    <= health_next;
            deadline_reg  <= deadline_next;
            attached_reg  <= attached_next;
            kind_reg      <= kind_next;
            full_seen_reg <= full_seen_next;
            once_full_reg <= once_full_next;
            enable_reg    <= enable_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_enable_only_chargeable: assert property (@(posedge clk) disable iff (!rst_n)
        enable_reg |-> state_reg == ST_CHARGEABLE)
        else $error("charger enabled outside chargeable state");

    a_deadline_armed: assert property (@(posedge clk) disable iff (!rst_n)
        deadline_reg != '0 |-> attached_reg && state_reg == ST_CHARGEABLE)
        else $error("deadline armed without attached chargeable battery");

    // a full interrupt may set the full flag with no cable, so it is not checked here
    a_detached_kind: assert property (@(posedge clk) disable iff (!rst_n)
        !attached_reg |-> kind_reg == KIND_NONE && !once_full_reg)
        else $error("cable state left over after detach");

    a_result_held: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=> out_valid_reg && $stable(state_reg)
                                       && $stable(status_reg))
        else $error("stalled result changed");

endmodule

// File: rtl/battery_charge_supervisor_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_supervisor_core
// Charger supervisor: one status result for every poll or event transaction.
// ----------------------------------------------------------------------------
// Use:
//   Input channel (in_valid / in_stall) carries one poll, cable change or
//   full-charge interrupt per transaction with time, temperature, cell
//   voltage and cable state. Output channel (out_valid / out_stall) returns
//   charge status, health, charger enable and supervisor state, one result
//   per input transaction, in order.
//   Configuration: write cfg_data to register cfg_index while cfg_we is
//   high; write only while no transaction is in flight.
// Timing:
//   The front classifies an item in the cycle it is accepted and pushes it
//   into a four-entry queue. The back pops one item per cycle while no
//   result is held or out_stall is low, runs the state update and registers
//   the result: the item is written into the queue at the accepting edge,
//   and out_valid rises at the edge on which the back pops it.
// Reset and stall:
//   Reset restores default thresholds, empties the queue and clears the
//   state. While out_stall is high the result holds; the queue absorbs up
//   to four further items, then in_stall rises.
// ----------------------------------------------------------------------------
module battery_charge_supervisor_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [22:0]        cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         cmd,
    input  logic [31:0]        now_sec,
    input  logic signed [11:0] temperature,
    input  logic [22:0]        cell_microvolts,
    input  logic               cable_present,
    input  logic [1:0]         cable_kind,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status_code,
    output logic [1:0]         health,
    output logic               charger_enable,
    output logic [1:0]         charge_state
);
    import bcs_pkg::*;

    cfg_t  cfg_reg;
    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  head_valid;
    item_t head_item;

    // Configuration registers: hold until rewritten
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hot_limit           <= 12'sd600;
            cfg_reg.hot_recover         <= 12'sd400;
            cfg_reg.cold_recover        <= 12'sd0;
            cfg_reg.cold_limit          <= -12'sd50;
            cfg_reg.resume_uv           <= 23'd4130000;
            cfg_reg.charge_time_limit   <= 20'd21600;
            cfg_reg.recharge_time_limit <= 20'd5400;
            cfg_reg.charge_only_boot    <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_HOT_LIMIT:           cfg_reg.hot_limit           <= cfg_data[TEMP_W-1:0];
                REG_HOT_RECOVER:         cfg_reg.hot_recover         <= cfg_data[TEMP_W-1:0];
                REG_COLD_RECOVER:        cfg_reg.cold_recover        <= cfg_data[TEMP_W-1:0];
                REG_COLD_LIMIT:          cfg_reg.cold_limit          <= cfg_data[TEMP_W-1:0];
                REG_RESUME_UV:           cfg_reg.resume_uv           <= cfg_data[UV_W-1:0];
                REG_CHARGE_TIME_LIMIT:   cfg_reg.charge_time_limit   <= cfg_data[LIMIT_W-1:0];
                REG_RECHARGE_TIME_LIMIT: cfg_reg.recharge_time_limit <= cfg_data[LIMIT_W-1:0];
                REG_CHARGE_ONLY_BOOT:    cfg_reg.charge_only_boot    <= cfg_data[0];
                default:                 cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Front: accept and classify against the temperature and voltage bands
    bcs_front u_front (
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .now_sec         (now_sec),
        .temperature     (temperature),
        .cell_microvolts (cell_microvolts),
        .cable_present   (cable_present),
        .cable_kind      (cable_kind),
        .cfg             (cfg_reg),
        .q_full          (q_full),
        .push            (push),
        .push_item       (push_item)
    );

    // Queue: decouple acceptance from execution
    bcs_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_item  (push_item),
        .full       (q_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    // Back: advance the supervisor and register the result
    bcs_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg            (cfg_reg),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .pop            (pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status_code    (status_code),
        .health         (health),
        .charger_enable (charger_enable),
        .charge_state   (charge_state)
    );

endmodule

// File: verif/battery_charge_supervisor_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// battery_charge_supervisor_core_tb
// Self-checking bench for the charger supervisor. A short directed table
// covers the field extremes, every command, cable kinds, recharge, timeout
// and deadline wrap. Phases of random transactions follow, each under its
// own threshold setting and one of four idling patterns. Every result is
// compared in order against an untimed model of the supervisor kept in this bench.
// ----------------------------------------------------------------------------
module battery_charge_supervisor_core_tb;
    import bcs_pkg::*;

    // Codes the package leaves unnamed: the spare command acts as a poll,
    // the spare cable kind counts as a non-usb cable
    localparam logic [1:0] CMD_SPARE  = 2'd3;
    localparam logic [1:0] KIND_AC    = 2'd2;
    localparam logic [1:0] KIND_SPARE = 2'd3;

    localparam int UV_MAX          = 5000000;
    localparam int LIMIT_MAX       = 1048575;
    localparam int NUM_PHASES      = 8;
    localparam int ITEMS_PER_PHASE = 125;
    localparam int SETTLE_CYCLES   = 4;
    localparam int MAX_PRINTED     = 100;

    // One input transaction, field for field as on the ports
    typedef struct packed {
        logic [1:0]         cmd;
        logic [31:0]        now;
        logic signed [11:0] temp;
        logic [22:0]        cell_uv;
        logic               present;
        logic [1:0]         kind;
    } stim_t;

    // One result transaction
    typedef struct packed {
        report_t    status;
        health_t    health;
        logic       enable;
        sup_state_t state;
    } charger_report_t;

    // Directed table row: the result is typed in only where 'typed' is set
    typedef struct packed {
        stim_t           stim;
        logic            typed;
        charger_report_t want;
    } dir_row_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [2:0]         cfg_index;
    logic [22:0]        cfg_data;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         cmd;
    logic [31:0]        now_sec;
    logic signed [11:0] temperature;
    logic [22:0]        cell_microvolts;
    logic               cable_present;
    logic [1:0]         cable_kind;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         status_code;
    logic [1:0]         health;
    logic               charger_enable;
    logic [1:0]         charge_state;

    // Copy of the configuration registers
    logic signed [11:0] cfg_hb;
    logic signed [11:0] cfg_hr;
    logic signed [11:0] cfg_lr;
    logic signed [11:0] cfg_lb;
    logic [22:0]        cfg_rv;
    logic [19:0]        cfg_cl;
    logic [19:0]        cfg_rl;
    logic               cfg_boot;

    // Copy of the supervisor state
    sup_state_t  m_state;
    report_t     m_report;
    health_t     m_health;
    logic [31:0] m_deadline;
    logic        m_attached;
    logic [1:0]  m_kind;
    logic        m_full_seen;
    logic        m_once_full;
    logic        m_enable;

    charger_report_t reports_due [$];

    int          gap_pct;
    int          stall_pct;
    int          err_count;
    int          sent_count;
    int          results_seen;
    logic [31:0] wall;

    battery_charge_supervisor_core u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .now_sec         (now_sec),
        .temperature     (temperature),
        .cell_microvolts (cell_microvolts),
        .cable_present   (cable_present),
        .cable_kind      (cable_kind),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status_code     (status_code),
        .health          (health),
        .charger_enable  (charger_enable),
        .charge_state    (charge_state)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Generous hard stop, far beyond the slowest legal run
    initial
    begin
        #3_000_000;
        $display("battery_charge_supervisor_core: mismatch");
        $finish;
    end

    // Receiver side: stall at the rate the current phase asks for
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    task automatic log_mismatch(input string msg);
        if (err_count < MAX_PRINTED)
            $display("MISMATCH: %s", msg);
        err_count++;
    endtask

    // Compare each accepted result transaction with the oldest expectation
    always @(posedge clk)
    begin : result_check
        charger_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (reports_due.size() == 0)
            begin
                log_mismatch($sformatf("result %0d arrived with nothing pending",
                                       results_seen));
            end
            else
            begin
                want = reports_due.pop_front();
                if (status_code !== want.status)
                    log_mismatch($sformatf("result %0d status_code %0d, want %0d",
                                           results_seen, status_code, want.status));
                if (health !== want.health)
                    log_mismatch($sformatf("result %0d health %0d, want %0d",
                                           results_seen, health, want.health));
                if (charger_enable !== want.enable)
                    log_mismatch($sformatf("result %0d charger_enable %0d, want %0d",
                                           results_seen, charger_enable, want.enable));
                if (charge_state !== want.state)
                    log_mismatch($sformatf("result %0d charge_state %0d, want %0d",
                                           results_seen, charge_state, want.state));
            end
            results_seen++;
        end
    end

    // Advance the supervisor copy by one transaction and return its result
    function automatic charger_report_t next_charger_report(input stim_t s);
        logic signed [11:0] t;
        logic               gate;
        logic               band;
        charger_report_t    r;
        t = s.temp;

        // Cable change and full interrupt act before the poll
        if (s.cmd == CMD_CABLE)
        begin
            if (s.present)
            begin
                m_attached = 1'b1;
                m_kind     = s.kind;
                if (cfg_boot || m_kind != KIND_USB)
                    m_report = RPT_CHARGING;
            end
            else
            begin
                m_full_seen = 1'b0;
                m_attached  = 1'b0;
                m_report    = RPT_DISCHARGING;
                m_kind      = KIND_NONE;
                m_once_full = 1'b0;
                m_deadline  = '0;
            end
            m_state  = ST_CHARGEABLE;
            m_enable = (m_kind != KIND_NONE);
        end
        else if (s.cmd == CMD_FULL)
        begin
            m_full_seen = 1'b1;
        end

        // Health with hysteresis: between the bands the old class holds
        band = (t <= cfg_hr) && (t >= cfg_lr);
        if (t >= cfg_hb)
            m_health = HL_OVERHEAT;
        else if (band)
            m_health = HL_GOOD;
        else if (t <= cfg_lb)
            m_health = HL_COLD;

        if (m_attached)
        begin
            // A usb cable only changes the report and arms the deadline in charge-only boot
            gate = cfg_boot || (m_kind != KIND_USB);
            case (m_state)
                ST_CHARGEABLE:
                begin
                    if (m_deadline != '0 && s.now > m_deadline)
                    begin
                        if (gate && s.cell_uv > FULL_ON_TIMEOUT_UV)
                            m_report = RPT_FULL;
                        m_once_full = 1'b1;
                        m_state     = ST_TIMEOUT;
                    end
                    else if (m_health == HL_OVERHEAT || m_health == HL_COLD)
                    begin
                        if (gate)
                            m_report = RPT_NOT_CHARGING;
                        m_state = ST_ABNORMAL;
                    end
                    else if (m_full_seen)
                    begin
                        if (gate)
                        begin
                            m_report    = RPT_FULL;
                            m_once_full = 1'b1;
                        end
                        m_state = ST_FULL;
                    end
                end
                ST_ABNORMAL:
                begin
                    if (band)
                    begin
                        m_state = ST_CHARGEABLE;
                        if (gate)
                            m_report = RPT_CHARGING;
                    end
                end
                default:
                begin
                    if (s.cell_uv < cfg_rv)
                        m_state = ST_CHARGEABLE;
                end
            endcase

            // Arm the deadline modulo 2^32; a sum of zero stays unarmed
            if (m_state == ST_CHARGEABLE)
            begin
                m_enable = 1'b1;
                if (m_deadline == '0 && gate)
                    m_deadline = s.now + (m_once_full ? cfg_rl : cfg_cl);
            end
            else
            begin
                m_enable   = 1'b0;
                m_deadline = '0;
            end
        end

        r.status = m_report;
        r.health = m_health;
        r.enable = m_enable;
        r.state  = m_state;
        return r;
    endfunction

    function automatic stim_t mk_stim(input logic [1:0] c, input logic [31:0] n,
                                      input int t, input int u, input logic p,
                                      input logic [1:0] k);
        stim_t s;
        s.cmd     = c;
        s.now     = n;
        s.temp    = t[11:0];
        s.cell_uv = u[22:0];
        s.present = p;
        s.kind    = k;
        return s;
    endfunction

    function automatic dir_row_t checked_row(input stim_t s);
        dir_row_t r;
        r       = '0;
        r.stim  = s;
        r.typed = 1'b0;
        return r;
    endfunction

    function automatic dir_row_t known_row(input stim_t s, input report_t st,
                                           input health_t h, input logic en,
                                           input sup_state_t ss);
        dir_row_t r;
        r.stim        = s;
        r.typed       = 1'b1;
        r.want.status = st;
        r.want.health = h;
        r.want.enable = en;
        r.want.state  = ss;
        return r;
    endfunction

    // Random transaction: mostly plausible charging sessions with time
    // advancing towards the deadline, temperatures near the thresholds and
    // voltages near the recharge and full levels; some pure noise
    function automatic stim_t rand_stim();
        stim_t s;
        int    pick;
        int    t;
        int    lo;
        int    hi;
        int    u;
        int    span;
        pick = $urandom_range(99);
        if (pick < 60)
            s.cmd = CMD_POLL;
        else if (pick < 75)
            s.cmd = CMD_CABLE;
        else if (pick < 88)
            s.cmd = CMD_FULL;
        else if (pick < 93)
            s.cmd = CMD_SPARE;
        else
            s.cmd = CMD_POLL;

        // Attach twice as often as detach so a cable is mostly present
        s.present = ($urandom_range(2) != 0);
        u = $urandom_range(2);
        s.kind = ($urandom_range(19) == 0) ? KIND_SPARE : u[1:0];

        span = cfg_cl;
        pick = $urandom_range(99);
        if (pick < 5)
            wall = $urandom;
        else if (pick < 20)
            wall = wall + $urandom_range(span * 2 + 10);
        else
            wall = wall + $urandom_range(span / 8 + 2);
        s.now = wall;

        lo   = cfg_lr;
        hi   = cfg_hr;
        pick = $urandom_range(99);
        if (pick < 50)
        begin
            case ($urandom_range(3))
                0:       t = cfg_hb;
                1:       t = cfg_hr;
                2:       t = cfg_lr;
                default: t = cfg_lb;
            endcase
            u = $urandom_range(6);
            t = t + u - 3;
        end
        else if (pick < 65 || hi < lo)
        begin
            t = $urandom;
        end
        else
        begin
            u = $urandom_range(hi - lo);
            t = lo + u;
        end
        s.temp = t[11:0];

        pick = $urandom_range(99);
        if (pick < 40)
        begin
            t = cfg_rv;
            u = $urandom_range(4000);
            u = t + u - 2000;
        end
        else if (pick < 60)
        begin
            t = FULL_ON_TIMEOUT_UV;
            u = $urandom_range(4000);
            u = t + u - 2000;
        end
        else
        begin
            u = $urandom_range(UV_MAX);
        end
        if (u < 0)
            u = 0;
        if (u > UV_MAX)
            u = UV_MAX;
        s.cell_uv = u[22:0];
        return s;
    endfunction

    // Present one transaction, hold it through any stall, then predict it
    task automatic send_row(input dir_row_t row);
        charger_report_t due;
        while ($urandom_range(99) < gap_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid        <= 1'b1;
        cmd             <= row.stim.cmd;
        now_sec         <= row.stim.now;
        temperature     <= row.stim.temp;
        cell_microvolts <= row.stim.cell_uv;
        cable_present   <= row.stim.present;
        cable_kind      <= row.stim.kind;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        due = next_charger_report(row.stim);
        if (row.typed)
            due = row.want;
        reports_due.push_back(due);
        sent_count++;
    endtask

    // Drop valid and wait until every pending result has been returned
    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (reports_due.size() != 0)
            @(posedge clk);
    endtask

    task automatic settle();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [22:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            REG_HOT_LIMIT:           cfg_hb   = val[11:0];
            REG_HOT_RECOVER:         cfg_hr   = val[11:0];
            REG_COLD_RECOVER:        cfg_lr   = val[11:0];
            REG_COLD_LIMIT:          cfg_lb   = val[11:0];
            REG_RESUME_UV:           cfg_rv   = val;
            REG_CHARGE_TIME_LIMIT:   cfg_cl   = val[19:0];
            REG_RECHARGE_TIME_LIMIT: cfg_rl   = val[19:0];
            REG_CHARGE_ONLY_BOOT:    cfg_boot = val[0];
            default: ;
        endcase
    endtask

    // Program all registers: minimum, maximum, fully random or a realistic
    // ordered set with short time limits so that timeouts happen
    task automatic program_setting(input int p);
        int hb;
        int hr;
        int lr;
        int lb;
        int rv;
        int cl;
        int rl;
        int boot;
        if (p == 1)
        begin
            hb = -2048; hr = -2048; lr = -2048; lb = -2048;
            rv = 0; cl = 0; rl = 0; boot = 0;
        end
        else if (p == 2)
        begin
            hb = 2047; hr = 2047; lr = 2047; lb = 2047;
            rv = UV_MAX; cl = LIMIT_MAX; rl = LIMIT_MAX; boot = 1;
        end
        else if (p == 4 || p == 7)
        begin
            hb = $urandom; hr = $urandom; lr = $urandom; lb = $urandom;
            rv = $urandom_range(UV_MAX);
            cl = $urandom; rl = $urandom;
            boot = $urandom_range(1);
        end
        else
        begin
            lb = $urandom_range(200);
            lb = lb - 150;
            lr = lb + $urandom_range(100);
            hr = lr + $urandom_range(500, 50);
            hb = hr + $urandom_range(300);
            rv = $urandom_range(4200000, 3900000);
            cl = $urandom_range(3000, 20);
            rl = $urandom_range(2000, 10);
            boot = $urandom_range(1);
        end
        write_reg(REG_HOT_LIMIT,           {{11{hb[11]}}, hb[11:0]});
        write_reg(REG_HOT_RECOVER,         {{11{hr[11]}}, hr[11:0]});
        write_reg(REG_COLD_RECOVER,        {{11{lr[11]}}, lr[11:0]});
        write_reg(REG_COLD_LIMIT,          {{11{lb[11]}}, lb[11:0]});
        write_reg(REG_RESUME_UV,           rv[22:0]);
        write_reg(REG_CHARGE_TIME_LIMIT,   {3'd0, cl[19:0]});
        write_reg(REG_RECHARGE_TIME_LIMIT, {3'd0, rl[19:0]});
        write_reg(REG_CHARGE_ONLY_BOOT,    {22'd0, boot[0]});
        cfg_we <= 1'b0;
    endtask

    initial
    begin : main_seq
        dir_row_t plan [$];
        int       p;
        int       i;
        int       n_directed;

        // Hold every input at a known value from time zero
        rst_n           = 1'b0;
        cfg_we          = 1'b0;
        cfg_index       = '0;
        cfg_data        = '0;
        in_valid        = 1'b0;
        cmd             = CMD_POLL;
        now_sec         = '0;
        temperature     = '0;
        cell_microvolts = '0;
        cable_present   = 1'b0;
        cable_kind      = KIND_NONE;
        gap_pct         = 0;
        stall_pct       = 0;
        err_count       = 0;
        sent_count      = 0;
        results_seen    = 0;
        wall            = '0;

        // Register and state values after reset
        cfg_hb      = 12'sd600;
        cfg_hr      = 12'sd400;
        cfg_lr      = 12'sd0;
        cfg_lb      = -12'sd50;
        cfg_rv      = 23'd4130000;
        cfg_cl      = 20'd21600;
        cfg_rl      = 20'd5400;
        cfg_boot    = 1'b0;
        m_state     = ST_CHARGEABLE;
        m_report    = RPT_DISCHARGING;
        m_health    = HL_GOOD;
        m_deadline  = '0;
        m_attached  = 1'b0;
        m_kind      = KIND_NONE;
        m_full_seen = 1'b0;
        m_once_full = 1'b0;
        m_enable    = 1'b0;

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // Directed table at the reset thresholds. No cable: only health
        // moves, through both temperature extremes and the gaps between
        // the bands, where the previous class must hold.
        plan.push_back(known_row(mk_stim(CMD_POLL, 32'd0, 250, 3800000, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_GOOD, 1'b0, ST_CHARGEABLE));
        plan.push_back(known_row(mk_stim(CMD_POLL, 32'd10, 2047, 3800000, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_OVERHEAT, 1'b0, ST_CHARGEABLE));
        plan.push_back(known_row(mk_stim(CMD_POLL, 32'd20, 500, 3800000, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_OVERHEAT, 1'b0, ST_CHARGEABLE));
        plan.push_back(known_row(mk_stim(CMD_POLL, 32'd30, -2048, 3800000, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_COLD, 1'b0, ST_CHARGEABLE));
        plan.push_back(known_row(mk_stim(CMD_POLL, 32'd40, -20, 3800000, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_COLD, 1'b0, ST_CHARGEABLE));
        plan.push_back(known_row(mk_stim(CMD_POLL, 32'd50, 200, 3800000, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_GOOD, 1'b0, ST_CHARGEABLE));
        // Spare command code behaves as a plain poll
        plan.push_back(known_row(mk_stim(CMD_SPARE, 32'd60, 200, 0, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_GOOD, 1'b0, ST_CHARGEABLE));
        // Usb cable outside charge-only boot: gate closed, then full and recharge
        plan.push_back(checked_row(mk_stim(CMD_CABLE, 32'd100, 200, 3900000, 1'b1, KIND_USB)));
        plan.push_back(checked_row(mk_stim(CMD_FULL, 32'd200, 200, 4200000, 1'b0, KIND_NONE)));
        plan.push_back(checked_row(mk_stim(CMD_POLL, 32'd250, 200, 4000000, 1'b0, KIND_NONE)));
        plan.push_back(known_row(mk_stim(CMD_CABLE, 32'd300, 200, 4000000, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_GOOD, 1'b0, ST_CHARGEABLE));
        // Ac cable: abnormal temperature and recovery, full, recharge, full again
        plan.push_back(checked_row(mk_stim(CMD_CABLE, 32'd1000, 200, 3900000, 1'b1, KIND_AC)));
        plan.push_back(checked_row(mk_stim(CMD_POLL, 32'd1100, 650, 3900000, 1'b0, KIND_NONE)));
        plan.push_back(checked_row(mk_stim(CMD_POLL, 32'd1200, 300, 3900000, 1'b0, KIND_NONE)));
        plan.push_back(checked_row(mk_stim(CMD_FULL, 32'd1300, 300, 4200000, 1'b0, KIND_NONE)));
        plan.push_back(checked_row(mk_stim(CMD_POLL, 32'd1400, 300, 4100000, 1'b0, KIND_NONE)));
        plan.push_back(checked_row(mk_stim(CMD_POLL, 32'd1500, 300, 4200000, 1'b0, KIND_NONE)));
        plan.push_back(known_row(mk_stim(CMD_CABLE, 32'd1600, 200, 4200000, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_GOOD, 1'b0, ST_CHARGEABLE));
        // Timeout with a high cell reported as full, then recharge at the
        // top of the time range, where the new deadline wraps
        plan.push_back(checked_row(mk_stim(CMD_CABLE, 32'd2000, 200, 4200000, 1'b1, KIND_AC)));
        plan.push_back(checked_row(mk_stim(CMD_POLL, 32'd30000, 200, 4200000, 1'b0, KIND_NONE)));
        plan.push_back(checked_row(mk_stim(CMD_POLL, 32'd30001, 200, UV_MAX, 1'b0, KIND_NONE)));
        plan.push_back(checked_row(mk_stim(CMD_POLL, 32'hFFFF_FFFF, 200, 0, 1'b0, KIND_NONE)));
        plan.push_back(known_row(mk_stim(CMD_CABLE, 32'd0, 200, 0, 1'b0, KIND_NONE),
                                 RPT_DISCHARGING, HL_GOOD, 1'b0, ST_CHARGEABLE));
        // Spare cable kind; the deadline sum wraps to exactly zero, unarmed
        plan.push_back(checked_row(mk_stim(CMD_CABLE, 32'hFFFF_ABA0, 200, 3900000, 1'b1,
                                           KIND_SPARE)));
        plan.push_back(checked_row(mk_stim(CMD_POLL, 32'hFFFF_FFFF, 200, 3900000, 1'b0,
                                           KIND_NONE)));
        // Cable seen but kind none: enable first cleared, then set by the poll step of the same transaction
        plan.push_back(checked_row(mk_stim(CMD_CABLE, 32'd5, 200, 4999999, 1'b1, KIND_NONE)));

        n_directed = plan.size();
        for (i = 0; i < n_directed; i++)
            send_row(plan[i]);
        settle();

        // Random phases; the idling pattern cycles through none, sender
        // gaps, receiver stalls and light gaps on both sides
        for (p = 0; p < NUM_PHASES; p++)
        begin
            program_setting(p);
            case (p % 4)
                0:       begin gap_pct = 0;  stall_pct <= 0;  end
                1:       begin gap_pct = 45; stall_pct <= 0;  end
                2:       begin gap_pct = 0;  stall_pct <= 45; end
                default: begin gap_pct = 8;  stall_pct <= 8;  end
            endcase
            for (i = 0; i < ITEMS_PER_PHASE; i++)
            begin
                // Pause the sender once per phase until the block runs dry
                if (i == ITEMS_PER_PHASE / 2)
                    drain_results();
                send_row(checked_row(rand_stim()));
            end
            settle();
        end

        $display("covered %0d directed and %0d random transactions over %0d settings",
                 n_directed, sent_count - n_directed, NUM_PHASES + 1);
        $display("%0d results compared, %0d mismatches", results_seen, err_count);
        if (err_count == 0 && reports_due.size() == 0)
            $display("battery_charge_supervisor_core: match");
        else
            $display("battery_charge_supervisor_core: mismatch");
        $finish;
    end

endmodule

// File: sim.f
rtl/bcs_pkg.sv
rtl/bcs_front.sv
rtl/bcs_queue.sv
rtl/bcs_back.sv
rtl/battery_charge_supervisor_core.sv
verif/battery_charge_supervisor_core_tb.sv
